FILE: rtl/lts_pkg.sv
// Shared types, sizes, weight table and saturating add for the linear three-class scorer.
package lts_pkg;

    localparam int NUM_FEATURES = 13;
    localparam int NUM_CLASSES  = 3;
    localparam int IDX_W        = $clog2(NUM_FEATURES + 1);
    localparam int FEAT_W       = 32;
    localparam int WEIGHT_W     = 16;
    localparam int PROD_W       = FEAT_W + WEIGHT_W;
    localparam int SCORE_W      = 56;
    localparam int BIAS_W       = 34;
    localparam int CFG_IDX_W    = 2;
    localparam int LABEL_W      = 2;

    typedef logic signed [FEAT_W-1:0]   t_feat;
    typedef logic signed [WEIGHT_W-1:0] t_weight;
    typedef logic signed [PROD_W-1:0]   t_prod;
    typedef logic signed [SCORE_W-1:0]  t_score;
    typedef logic signed [BIAS_W-1:0]   t_bias;
    typedef logic [IDX_W-1:0]           t_idx;
    typedef logic [CFG_IDX_W-1:0]       t_cfg_idx;
    typedef logic [LABEL_W-1:0]         t_label;

    localparam t_idx LAST_IDX = IDX_W'(NUM_FEATURES - 1);

    // register indexes on the config port
    localparam t_cfg_idx REG_BIAS0 = 2'd0;
    localparam t_cfg_idx REG_BIAS1 = 2'd1;
    localparam t_cfg_idx REG_BIAS2 = 2'd2;

    localparam t_label LABEL_C0 = 2'd0;
    localparam t_label LABEL_C1 = 2'd1;
    localparam t_label LABEL_C2 = 2'd2;

    localparam t_bias BIAS0_RST = -34'sd2065771895;
    localparam t_bias BIAS1_RST =  34'sd2195587282;
    localparam t_bias BIAS2_RST =  34'sd6985549559;

    // Q2.14 weights, one row per class
    localparam t_weight WEIGHT_Q14 [NUM_CLASSES][NUM_FEATURES] = '{
        '{  16'sd202,   16'sd5761, -16'sd1579, -16'sd4037,   16'sd750, -16'sd7912,
           -16'sd981,   16'sd1763,   16'sd369,  -16'sd714,  16'sd3285,  -16'sd242,
            16'sd3203 },
        '{ -16'sd3611,  16'sd5715,  16'sd2697, -16'sd8993, -16'sd7778, -16'sd10915,
           -16'sd3693, -16'sd8679, -16'sd6732, -16'sd8867,  16'sd4889,   16'sd213,
            16'sd7071 },
        '{ -16'sd3056, -16'sd5715, -16'sd3134,  16'sd1093,  16'sd1989,  16'sd1027,
            16'sd2833,  16'sd1250, -16'sd2674,  16'sd1596,   16'sd426,  16'sd2133,
           -16'sd2998 }
    };

    function automatic t_weight weight_of(input int c, input t_idx f);
        t_weight w;
        w = '0;
        if (int'(f) < NUM_FEATURES) begin
            w = WEIGHT_Q14[c][f];
        end
        return w;
    endfunction

    // signed add clamped to the score range
    function automatic t_score sat_add(input t_score a, input t_score b);
        logic signed [SCORE_W:0] s;
        t_score r;
        s = {a[SCORE_W-1], a} + {b[SCORE_W-1], b};
        if (s[SCORE_W] != s[SCORE_W-1]) begin
            r = s[SCORE_W] ? {1'b1, {(SCORE_W-1){1'b0}}} : {1'b0, {(SCORE_W-1){1'b1}}};
        end else begin
            r = s[SCORE_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/linear_three_class_scorer.sv
// Linear three-class scorer: streamed dot products, bias, positive-max class pick.
// Throughput: one feature per cycle while the input is not stalled; one result per NUM_FEATURES features.
// After the last feature of a vector is accepted, its result passes through the input reg,
//   multiply, accumulate, bias add, and compare into the output reg, in that order.
// The pipeline stalls only when a new result is ready and the held one is stalled.
// Reset (sync, active low) clears accumulators, feature count and valids,
//   and loads the bias registers with their default values.
module linear_three_class_scorer (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  lts_pkg::t_feat           i_feature_value,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic                     o_class_found,
    output lts_pkg::t_label          o_class_label,
    output lts_pkg::t_score          o_score0,
    output lts_pkg::t_score          o_score1,
    output lts_pkg::t_score          o_score2,
    input  logic                     i_cfg_we,
    input  lts_pkg::t_cfg_idx        i_cfg_index,
    input  lts_pkg::t_bias           i_cfg_data
);
    import lts_pkg::*;

    logic    advance;
    logic    accept;

    t_bias   r_bias [NUM_CLASSES];
    t_idx    r_idx;

    // stage 1: input register
    logic    r_v1, r_last1;
    t_feat   r_x;
    t_weight r_w [NUM_CLASSES];

    // stage 2: products
    logic    r_v2, r_last2;
    t_prod   r_prod [NUM_CLASSES];

    // stage 3: accumulators and completed sums
    t_score  r_acc [NUM_CLASSES];
    t_score  n_acc [NUM_CLASSES];
    logic    r_v3;
    t_score  r_sum [NUM_CLASSES];

    // stage 4: biased scores
    logic    r_v4;
    t_score  r_score [NUM_CLASSES];

    // output register
    logic    r_out_valid;
    logic    r_found;
    t_label  r_label;
    t_score  r_out_score [NUM_CLASSES];

    logic    pos0, pos1, pos2, gt01, gt02, gt12, b1, win2;
    logic    n_found;
    t_label  n_label;

    assign advance    = !(r_v4 && r_out_valid && i_out_stall);
    assign accept     = i_in_valid && advance;
    assign o_in_stall = !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias[0] <= BIAS0_RST;
            r_bias[1] <= BIAS1_RST;
            r_bias[2] <= BIAS2_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_BIAS0) begin
                r_bias[0] <= i_cfg_data;
            end
            if (i_cfg_index == REG_BIAS1) begin
                r_bias[1] <= i_cfg_data;
            end
            if (i_cfg_index == REG_BIAS2) begin
                r_bias[2] <= i_cfg_data;
            end
        end
    end

    // feature count and stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_v1    <= 1'b0;
            r_last1 <= 1'b0;
        end else if (advance) begin
            r_v1 <= i_in_valid;
            if (i_in_valid) begin
                r_last1 <= (r_idx == LAST_IDX);
                r_idx   <= (r_idx == LAST_IDX) ? '0 : r_idx + t_idx'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_feature_value;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_w[c] <= weight_of(c, r_idx);
            end
        end
    end

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2    <= 1'b0;
            r_last2 <= 1'b0;
        end else if (advance) begin
            r_v2    <= r_v1;
            r_last2 <= r_last1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v1) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_prod[c] <= r_x * r_w[c];
            end
        end
    end

    // stage 3
    always_comb begin
        for (int c = 0; c < NUM_CLASSES; c++) begin
            n_acc[c] = sat_add(r_acc[c], SCORE_W'(r_prod[c]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_acc[c] <= '0;
            end
        end else if (advance) begin
            r_v3 <= r_v2 && r_last2;
            if (r_v2) begin
                for (int c = 0; c < NUM_CLASSES; c++) begin
                    r_acc[c] <= r_last2 ? '0 : n_acc[c];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v2 && r_last2) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_sum[c] <= n_acc[c];
            end
        end
    end

    // stage 4: bias add
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
        end else if (advance) begin
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v3) begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_score[c] <= sat_add(r_sum[c], SCORE_W'(r_bias[c]));
            end
        end
    end

    // winner pick: parallel compares, ties keep the lower class
    always_comb begin
        pos0    = r_score[0] > t_score'(0);
        pos1    = r_score[1] > t_score'(0);
        pos2    = r_score[2] > t_score'(0);
        gt01    = r_score[1] > r_score[0];
        gt02    = r_score[2] > r_score[0];
        gt12    = r_score[2] > r_score[1];
        b1      = pos0 ? gt01 : pos1;
        win2    = b1 ? gt12 : (pos0 ? gt02 : pos2);
        n_found = pos0 || pos1 || pos2;
        n_label = win2 ? LABEL_C2 : (b1 ? LABEL_C1 : LABEL_C0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_v4) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_v4) begin
            r_found <= n_found;
            r_label <= n_label;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_out_score[c] <= r_score[c];
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_class_found = r_found;
    assign o_class_label = r_label;
    assign o_score0      = r_out_score[0];
    assign o_score1      = r_out_score[1];
    assign o_score2      = r_out_score[2];

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= LAST_IDX)
        else $error("feature count out of range");

    a_sum_follows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_v2 && r_last2) |=> r_v3)
        else $error("completed vector lost before bias stage");

    a_out_from_stage4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_v4))
        else $error("result appeared without a biased score");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_out_valid && i_out_stall && r_v4))
        else $error("input stalled without a blocked result");

    a_label_none: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_class_found) |-> (o_class_label == LABEL_C0))
        else $error("label set without a positive score");

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the linear three-class scorer: predicts scores and class picks.
module testbench;
    import lts_pkg::*;

    localparam t_cfg_idx REG_UNUSED    = 2'd3;
    localparam int       SETTLE_CYCLES = 8;
    localparam int       MAX_REPORTS   = 200;

    localparam t_feat  FEAT_MAX = 32'sh7fff_ffff;
    localparam t_feat  FEAT_MIN = 32'sh8000_0000;
    localparam t_feat  FEAT_EDGES [5] = '{FEAT_MAX, FEAT_MIN, 32'sd0, -32'sd1, 32'sd1};
    localparam t_bias  BIAS_MAX = {1'b0, {33{1'b1}}};
    localparam t_bias  BIAS_MIN = {1'b1, {33{1'b0}}};
    localparam longint SCORE_HI = (64'sd1 <<< 55) - 64'sd1;
    localparam longint SCORE_LO = -SCORE_HI - 64'sd1;

    // Q2.14 weights, class by feature
    localparam int WEIGHTS [NUM_CLASSES][NUM_FEATURES] = '{
        '{  202,  5761, -1579, -4037,   750,  -7912,  -981,  1763,   369,  -714,  3285,  -242,  3203},
        '{-3611,  5715,  2697, -8993, -7778, -10915, -3693, -8679, -6732, -8867,  4889,   213,  7071},
        '{-3056, -5715, -3134,  1093,  1989,   1027,  2833,  1250, -2674,  1596,   426,  2133, -2998}
    };

    typedef struct packed {
        logic   found;
        t_label label;
        t_score s0;
        t_score s1;
        t_score s2;
    } t_outcome;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_feat     i_feature_value = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    logic      o_class_found;
    t_label    o_class_label;
    t_score    o_score0;
    t_score    o_score1;
    t_score    o_score2;
    logic      i_cfg_we = 1'b0;
    t_cfg_idx  i_cfg_index = REG_BIAS0;
    t_bias     i_cfg_data = '0;

    longint    run_score [NUM_CLASSES];
    t_bias     bias_now [NUM_CLASSES];
    int        feat_count;
    t_outcome  vector_outcomes [$];
    int        error_count = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_len = 0;

    linear_three_class_scorer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_feature_value (i_feature_value),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_class_found   (o_class_found),
        .o_class_label   (o_class_label),
        .o_score0        (o_score0),
        .o_score1        (o_score1),
        .o_score2        (o_score2),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #(8 * 200000);
        $display("testbench failed");
        $finish;
    end

    function automatic longint clamp_score(input longint v);
        if (v > SCORE_HI) begin
            return SCORE_HI;
        end
        if (v < SCORE_LO) begin
            return SCORE_LO;
        end
        return v;
    endfunction

    // fold one feature into the running scores; emits a class pick on the last one
    function automatic void fold_feature(input t_feat x);
        t_outcome res;
        longint   best;
        foreach (run_score[c]) begin
            run_score[c] = clamp_score(run_score[c] + longint'(x) * WEIGHTS[c][feat_count]);
        end
        feat_count++;
        if (feat_count == NUM_FEATURES) begin
            best = 0;
            res = '0;
            res.label = LABEL_C0;
            foreach (run_score[c]) begin
                run_score[c] = clamp_score(run_score[c] + longint'(bias_now[c]));
                // strict compare: ties keep the lower class
                if (run_score[c] > best) begin
                    best = run_score[c];
                    res.found = 1'b1;
                    res.label = t_label'(c);
                end
            end
            res.s0 = t_score'(run_score[0]);
            res.s1 = t_score'(run_score[1]);
            res.s2 = t_score'(run_score[2]);
            vector_outcomes.push_back(res);
            foreach (run_score[c]) begin
                run_score[c] = 0;
            end
            feat_count = 0;
        end
    endfunction

    task automatic report_mismatch(input string what, input logic signed [63:0] got,
                                   input logic signed [63:0] want);
        if (error_count < MAX_REPORTS) begin
            $display("%0t mismatch on %s: got %0d, want %0d", $realtime, what, got, want);
        end
        error_count++;
    endtask

    always @(posedge i_clk) begin : result_check
        t_outcome want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (vector_outcomes.size() == 0) begin
                report_mismatch("unexpected result, score0", o_score0, 0);
            end else begin
                want = vector_outcomes.pop_front();
                if (o_class_found !== want.found)
                    report_mismatch("class_found", o_class_found, want.found);
                if (o_class_label !== want.label)
                    report_mismatch("class_label", o_class_label, want.label);
                if (o_score0 !== want.s0) report_mismatch("score0", o_score0, want.s0);
                if (o_score1 !== want.s1) report_mismatch("score1", o_score1, want.s1);
                if (o_score2 !== want.s2) report_mismatch("score2", o_score2, want.s2);
            end
        end
    end

    // receiver: random stall, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_len > 0) begin
            i_out_stall <= 1'b1;
            hold_len--;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_feature(input t_feat value);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_feature_value <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        fold_feature(value);
    endtask

    task automatic send_vector(input t_feat feats [NUM_FEATURES]);
        foreach (feats[i]) begin
            send_feature(feats[i]);
        end
    endtask

    // drain every pending result, then let the pipeline go quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (vector_outcomes.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input t_bias data);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            REG_BIAS0: bias_now[0] = data;
            REG_BIAS1: bias_now[1] = data;
            REG_BIAS2: bias_now[2] = data;
            default: ;
        endcase
    endtask

    function automatic t_bias rand_bias();
        case ($urandom_range(5))
            0: return BIAS_MAX;
            1: return BIAS_MIN;
            2: return '0;
            3: return t_bias'(int'($urandom_range(1 << 28)) - (1 << 27));
            default: return t_bias'({$urandom(), $urandom()});
        endcase
    endfunction

    task automatic load_random_biases();
        t_bias shared;
        shared = rand_bias();
        if ($urandom_range(3) == 0) begin
            // equal biases make ties likely on small vectors
            write_reg(REG_BIAS0, shared);
            write_reg(REG_BIAS1, shared);
            write_reg(REG_BIAS2, shared);
        end else begin
            write_reg(REG_BIAS0, rand_bias());
            write_reg(REG_BIAS1, rand_bias());
            write_reg(REG_BIAS2, rand_bias());
        end
        if ($urandom_range(7) == 0) begin
            write_reg(REG_UNUSED, rand_bias());
        end
    endtask

    task automatic test_reset_bias();
        t_feat v [NUM_FEATURES];
        foreach (v[i]) v[i] = FEAT_EDGES[i % 5];
        send_vector(v);
    endtask

    task automatic test_unknown_index();
        t_feat v [NUM_FEATURES];
        settle();
        write_reg(REG_UNUSED, BIAS_MAX);
        foreach (v[i]) v[i] = '0;
        send_vector(v);
    endtask

    // bias is taken when the vector completes, not when it starts
    task automatic test_midvector_bias();
        settle();
        for (int i = 0; i < 6; i++) send_feature('0);
        settle();
        write_reg(REG_BIAS0, BIAS_MAX);
        write_reg(REG_BIAS1, BIAS_MAX);
        write_reg(REG_BIAS2, BIAS_MIN);
        for (int i = 6; i < NUM_FEATURES; i++) send_feature('0);
    endtask

    task automatic test_class_picks();
        t_feat v [NUM_FEATURES];
        foreach (v[i]) v[i] = '0;
        settle();
        // all scores exactly zero: nothing found
        write_reg(REG_BIAS0, '0);
        write_reg(REG_BIAS1, '0);
        write_reg(REG_BIAS2, '0);
        send_vector(v);
        settle();
        write_reg(REG_BIAS0, BIAS_MIN);
        write_reg(REG_BIAS1, BIAS_MAX);
        write_reg(REG_BIAS2, BIAS_MAX);
        send_vector(v);
    endtask

    task automatic test_random_vectors();
        int    pace [5][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{7, 7}, '{0, 0}};
        t_feat v [NUM_FEATURES];
        int    mode;
        for (int p = 0; p < 5; p++) begin
            settle();
            send_idle_pct = pace[p][0];
            stall_pct = pace[p][1];
            for (int n = 0; n < 16; n++) begin
                if (n % 4 == 0) begin
                    settle();
                    load_random_biases();
                end
                mode = $urandom_range(9);
                foreach (v[i]) begin
                    if (mode <= 3 || mode == 9) begin
                        v[i] = t_feat'($urandom());
                    end else if (mode <= 5) begin
                        v[i] = t_feat'(int'($urandom_range(1 << 20)) - (1 << 19));
                    end else if (mode == 6) begin
                        v[i] = FEAT_EDGES[$urandom_range(4)];
                    end else if (mode == 7) begin
                        v[i] = '0;
                    end else begin
                        v[i] = (i == 0) ? t_feat'($urandom()) : v[0];
                    end
                end
                send_vector(v);
            end
        end
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
    endtask

    // receiver holds off while features keep coming, so the input backs up
    task automatic test_output_holdoff();
        t_feat v [NUM_FEATURES];
        settle();
        send_idle_pct = 0;
        stall_pct = 0;
        hold_len = 400;
        repeat (4) begin
            foreach (v[i]) v[i] = t_feat'($urandom());
            send_vector(v);
        end
        settle();
    endtask

    initial begin
        foreach (run_score[c]) run_score[c] = 0;
        bias_now[0] = -34'sd2065771895;
        bias_now[1] = 34'sd2195587282;
        bias_now[2] = 34'sd6985549559;
        feat_count = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_bias();
        test_unknown_index();
        test_midvector_bias();
        test_class_picks();
        test_random_vectors();
        test_output_holdoff();

        settle();
        if (error_count == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/lts_pkg.sv
rtl/linear_three_class_scorer.sv
verif/testbench.sv
